>>> sv/spdl_pkg.sv
// Shared types, constants and register codes of the signed pair distance loss unit.
// Used by the channel interfaces and every module of the block; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package spdl_pkg;

  // Field types
  typedef logic signed [15:0] feat_t;   // Q4.12 feature element
  typedef logic        [15:0] label_t;  // class label
  typedef logic        [15:0] rate_t;   // unsigned Q4.12 weight
  typedef logic signed [47:0] q24_t;    // signed Q.24 loss, bias, threshold
  typedef logic        [46:0] sum_t;    // unsigned Q.24 running square sum
  typedef logic signed [21:0] sd_t;     // signed Q.12 scaled difference
  typedef logic        [1:0]  cfg_idx_t;
  typedef logic        [47:0] cfg_data_t;

  // Register indexes on the configuration channel
  typedef enum logic [1:0] {
    REG_LEARN_RATE     = 2'd0,
    REG_LOSS_OFFSET    = 2'd1,
    REG_LOSS_THRESHOLD = 2'd2
  } reg_idx_e;

  localparam rate_t RATE_RESET = 16'd4096;          // 1.0 in Q4.12
  localparam sum_t  SUM_MAX    = 47'h7FFF_FFFF_FFFF;
  localparam q24_t  LOSS_MAX   = 48'sh7FFF_FFFF_FFFF;
  localparam q24_t  LOSS_MIN   = 48'sh8000_0000_0000;

  // Configuration register file contents
  typedef struct packed {
    rate_t rate;
    q24_t  offset;
    q24_t  thresh;
  } cfg_t;

  // Element stage result handed to the loss pipeline
  typedef struct packed {
    sd_t  sd;       // scaled difference of this element
    logic last;     // last element of the pair
    logic same;     // labels match
    sum_t fin_sum;  // square sum including this element
  } elem_res_t;

endpackage

`default_nettype wire

>>> sv/spdl_if.sv
// Valid/ready channel interfaces: input element, result and configuration write.
// Depends on spdl_pkg for the field types.
`timescale 1ns / 1ps
`default_nettype none

interface spdl_in_if import spdl_pkg::*; ();
  logic   valid;
  logic   ready;
  feat_t  feat_x;
  feat_t  feat_y;
  label_t label_x;
  label_t label_y;
  logic   last;

  modport source (output valid, feat_x, feat_y, label_x, label_y, last, input ready);
  modport sink   (input valid, feat_x, feat_y, label_x, label_y, last, output ready);
endinterface

interface spdl_out_if import spdl_pkg::*; ();
  logic valid;
  logic ready;
  sd_t  scaled_diff;
  q24_t loss;
  logic above_thresh;
  logic done_res;

  modport source (output valid, scaled_diff, loss, above_thresh, done_res, input ready);
  modport sink   (input valid, scaled_diff, loss, above_thresh, done_res, output ready);
endinterface

interface spdl_cfg_if import spdl_pkg::*; ();
  logic      valid;
  logic      ready;
  cfg_idx_t  index;
  cfg_data_t data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

>>> sv/spdl_cfg.sv
// Configuration register file: learn rate, loss offset and loss threshold.
// Depends on spdl_pkg for cfg_t and the register index codes.
`timescale 1ns / 1ps
`default_nettype none

module spdl_cfg import spdl_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      wr_valid_i,
  output logic      wr_ready_o,
  input  cfg_idx_t  wr_index_i,
  input  cfg_data_t wr_data_i,
  output cfg_t      cfg_o
);

  cfg_t cfg_q;

  // Writes always complete; unknown indexes are dropped
  assign wr_ready_o = 1'b1;
  assign cfg_o      = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.rate   <= RATE_RESET;
      cfg_q.offset <= '0;
      cfg_q.thresh <= '0;
    end else if (wr_valid_i) begin
      case (reg_idx_e'(wr_index_i))
        REG_LEARN_RATE:     cfg_q.rate   <= wr_data_i[15:0];
        REG_LOSS_OFFSET:    cfg_q.offset <= q24_t'(wr_data_i);
        REG_LOSS_THRESHOLD: cfg_q.thresh <= q24_t'(wr_data_i);
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

>>> sv/spdl_elem.sv
// Element pipeline: input register, difference and products, then rounding and the
// saturating square-sum accumulator. Depends on spdl_pkg.
`timescale 1ns / 1ps
`default_nettype none

module spdl_elem import spdl_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  feat_t     feat_x_i,
  input  feat_t     feat_y_i,
  input  label_t    label_x_i,
  input  label_t    label_y_i,
  input  logic      last_i,
  input  rate_t     rate_i,
  output logic      res_valid_o,
  input  logic      res_ready_i,
  output elem_res_t res_o
);

  logic en1, en2, en3;

  // Stage 1: input register
  logic   v1_q;
  feat_t  x1_q, y1_q;
  label_t lx1_q, ly1_q;
  logic   last1_q;

  // Stage 2: magnitude products
  logic        v2_q;
  logic [31:0] prod2_q, prod2_d;
  logic [31:0] sq2_q, sq2_d;
  logic        neg2_q, neg2_d;
  logic        same2_q, same2_d;
  logic        last2_q;

  // Stage 3: rounded difference and accumulator
  logic      v3_q;
  elem_res_t res3_q, res3_d;
  sum_t      sum_q, sum_d;

  // Pipeline advance: a stage moves when empty or when its successor moves
  assign en3        = !v3_q || res_ready_i;
  assign en2        = !v2_q || en3;
  assign en1        = !v1_q || en2;
  assign in_ready_o = en1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (en1) v1_q <= in_valid_i;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1 && in_valid_i) begin
      x1_q    <= feat_x_i;
      y1_q    <= feat_y_i;
      lx1_q   <= label_x_i;
      ly1_q   <= label_y_i;
      last1_q <= last_i;
    end
  end

  // Difference magnitude, sign of the scaled result, two 16x16 products
  logic signed [16:0] diff;
  logic        [16:0] diff_neg;
  logic        [15:0] dmag;

  always_comb begin
    diff     = {x1_q[15], x1_q} - {y1_q[15], y1_q};
    diff_neg = 17'd0 - diff;
    dmag     = diff[16] ? diff_neg[15:0] : diff[15:0];
    same2_d  = (lx1_q == ly1_q);
    neg2_d   = diff[16] ^ !same2_d;
    prod2_d  = 32'(dmag) * 32'(rate_i);
    sq2_d    = 32'(dmag) * 32'(dmag);
  end

  always_ff @(posedge clk_i) begin
    if (en2 && v1_q) begin
      prod2_q <= prod2_d;
      sq2_q   <= sq2_d;
      neg2_q  <= neg2_d;
      same2_q <= same2_d;
      last2_q <= last1_q;
    end
  end

  // Round Q8.24 product to Q.12 (ties away from zero); saturating square sum
  logic [32:0] rnd;
  logic [21:0] smag_ext;
  logic [47:0] acc;
  sum_t        sum_sat;

  always_comb begin
    rnd            = {1'b0, prod2_q} + 33'd2048;
    smag_ext       = {1'b0, rnd[32:12]};
    acc            = {1'b0, sum_q} + {16'd0, sq2_q};
    sum_sat        = acc[47] ? SUM_MAX : acc[46:0];
    res3_d.sd      = neg2_q ? sd_t'(22'd0 - smag_ext) : sd_t'(smag_ext);
    res3_d.last    = last2_q;
    res3_d.same    = same2_q;
    res3_d.fin_sum = sum_sat;
    sum_d          = last2_q ? '0 : sum_sat;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
    end else if (en3 && v2_q) begin
      sum_q <= sum_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en3 && v2_q) res3_q <= res3_d;
  end

  assign res_valid_o = v3_q;
  assign res_o       = res3_q;

  // Checks
  a_sum_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en3 && v2_q && last2_q) |=> (sum_q == '0))
    else $error("square sum not cleared after last element");

  a_full_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (v1_q && v2_q && v3_q && !res_ready_i))
    else $error("input stalled while element pipeline has a bubble");

endmodule

`default_nettype wire

>>> sv/spdl_loss.sv
// Loss pipeline: weighted sum, bias subtract, rounding with saturation, threshold
// compare into the output register. Depends on spdl_pkg.
`timescale 1ns / 1ps
`default_nettype none

module spdl_loss import spdl_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cfg_t      cfg_i,
  input  logic      up_valid_i,
  output logic      up_ready_o,
  input  elem_res_t up_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output sd_t       scaled_diff_o,
  output q24_t      loss_o,
  output logic      above_o,
  output logic      done_o
);

  logic en4, en5, en6, en7;
  logic v4_q, v5_q, v6_q, v7_q;

  // Per-stage payload
  logic [62:0] w4_q;
  sd_t         sd4_q, sd5_q, sd6_q, sd7_q;
  logic        last4_q, last5_q, last6_q, last7_q;
  logic        same4_q;
  logic [63:0] mag5_q, mag5_d;
  logic        neg5_q, neg5_d;
  q24_t        loss6_q, loss6_d;
  q24_t        loss7_q;
  logic        above7_q, above7_d;

  assign en7        = !v7_q || out_ready_i;
  assign en6        = !v6_q || en7;
  assign en5        = !v5_q || en6;
  assign en4        = !v4_q || en5;
  assign up_ready_o = en4;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
      v7_q <= 1'b0;
    end else begin
      if (en4) v4_q <= up_valid_i;
      if (en5) v5_q <= v4_q;
      if (en6) v6_q <= v5_q;
      if (en7) v7_q <= v6_q;
    end
  end

  // Stage 4: rate * square sum, exact Q.36 (16 x 47 bits)
  always_ff @(posedge clk_i) begin
    if (en4 && up_valid_i) begin
      w4_q    <= 63'(up_i.fin_sum) * 63'(cfg_i.rate);
      sd4_q   <= up_i.sd;
      last4_q <= up_i.last;
      same4_q <= up_i.same;
    end
  end

  // Stage 5: subtract bias in Q.36, split into sign and magnitude
  logic [64:0] w_ext, b_ext, diff, diff_neg;

  always_comb begin
    w_ext    = {2'b00, w4_q};
    b_ext    = {{5{cfg_i.offset[47]}}, cfg_i.offset, 12'd0};
    diff     = w_ext - b_ext;
    diff_neg = b_ext - w_ext;
    mag5_d   = diff[64] ? diff_neg[63:0] : diff[63:0];
    neg5_d   = diff[64] ^ !same4_q;
  end

  always_ff @(posedge clk_i) begin
    if (en5 && v4_q) begin
      mag5_q  <= mag5_d;
      neg5_q  <= neg5_d;
      sd5_q   <= sd4_q;
      last5_q <= last4_q;
    end
  end

  // Stage 6: halve and drop to Q.24 (ties away from zero), apply sign, saturate
  logic [64:0] rq;
  logic [51:0] q;
  logic        qneg;

  always_comb begin
    rq   = {1'b0, mag5_q} + 65'd4096;
    q    = rq[64:13];
    qneg = neg5_q && (q != '0);
    if (!last5_q) begin
      loss6_d = '0;
    end else if (qneg) begin
      loss6_d = (q > 52'h8000_0000_0000) ? LOSS_MIN : q24_t'(48'd0 - q[47:0]);
    end else begin
      loss6_d = (q > 52'h7FFF_FFFF_FFFF) ? LOSS_MAX : q24_t'(q[47:0]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en6 && v5_q) begin
      loss6_q <= loss6_d;
      sd6_q   <= sd5_q;
      last6_q <= last5_q;
    end
  end

  // Stage 7: threshold compare into the output register
  assign above7_d = last6_q && (loss6_q >= cfg_i.thresh);

  always_ff @(posedge clk_i) begin
    if (en7 && v6_q) begin
      loss7_q  <= loss6_q;
      above7_q <= above7_d;
      sd7_q    <= sd6_q;
      last7_q  <= last6_q;
    end
  end

  assign out_valid_o   = v7_q;
  assign scaled_diff_o = sd7_q;
  assign loss_o        = loss7_q;
  assign above_o       = above7_q;
  assign done_o        = last7_q;

  // Checks
  a_idle_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v7_q && !last7_q) |-> (loss7_q == '0 && !above7_q))
    else $error("loss fields set on a result that is not the last");

  a_full_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !up_ready_o |-> (v4_q && v5_q && v6_q && v7_q && !out_ready_i))
    else $error("loss pipeline stalled with a bubble");

  a_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (up_valid_i && up_ready_o) |=> v4_q)
    else $error("accepted element result lost in stage 4");

endmodule

`default_nettype wire

>>> sv/signed_pair_distance_loss_unit.sv
// Signed pair distance loss unit: one element pair in, one result out per transaction.
// Channels: in_i (feat_x, feat_y, label_x, label_y, last), out_o results
// (scaled_diff, loss, above_thresh, done_res) and cfg_i register writes
// (index 0 learn_rate, 1 loss_offset, 2 loss_threshold; other indexes ignored).
// Throughput: one item per cycle while out_o is ready. The square-sum accumulator
// is a single add-and-saturate in one stage; both element products share a stage
// and the weighting multiply has one of its own. The item passes seven registers
// (input register, products, accumulate, weighting multiply, bias subtract,
// round/saturate, threshold compare and output register) on its way to out_o.
// Every item gives one result; loss and above_thresh are zero unless done_res is set,
// and the square sum is cleared after each last item.
// Stall: each stage advances when it is empty or its successor advances, so the
// unit keeps taking items until all seven stages hold data while out_o is stalled.
// Reset: rst_ni is asynchronous, active low; it empties the pipeline, clears the
// square sum and loads learn_rate 1.0, loss_offset 0 and loss_threshold 0.
// Configuration writes are always taken (cfg_i.ready stays high) and should be
// issued only while the unit is idle. Depends on spdl_pkg, spdl_if, spdl_cfg,
// spdl_elem and spdl_loss.
`timescale 1ns / 1ps
`default_nettype none

module signed_pair_distance_loss_unit import spdl_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  spdl_in_if.sink    in_i,
  spdl_cfg_if.sink   cfg_i,
  spdl_out_if.source out_o
);

  cfg_t      cfg;
  logic      elem_valid;
  logic      elem_ready;
  elem_res_t elem_res;

  // Register file
  spdl_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (cfg_i.valid),
    .wr_ready_o (cfg_i.ready),
    .wr_index_i (cfg_i.index),
    .wr_data_i  (cfg_i.data),
    .cfg_o      (cfg)
  );

  // Per-element stages and accumulator
  spdl_elem u_elem (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .feat_x_i    (in_i.feat_x),
    .feat_y_i    (in_i.feat_y),
    .label_x_i   (in_i.label_x),
    .label_y_i   (in_i.label_y),
    .last_i      (in_i.last),
    .rate_i      (cfg.rate),
    .res_valid_o (elem_valid),
    .res_ready_i (elem_ready),
    .res_o       (elem_res)
  );

  // Loss stages and output register
  spdl_loss u_loss (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .up_valid_i    (elem_valid),
    .up_ready_o    (elem_ready),
    .up_i          (elem_res),
    .out_valid_o   (out_o.valid),
    .out_ready_i   (out_o.ready),
    .scaled_diff_o (out_o.scaled_diff),
    .loss_o        (out_o.loss),
    .above_o       (out_o.above_thresh),
    .done_o        (out_o.done_res)
  );

endmodule

`default_nettype wire
